// ----- design/crd_pkg.sv -----
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types and constants of the record deframer: phase codes, result
// status codes and the result bundle that travels from the core to the
// output register.
// ----------------------------------------------------------------------------
package crd_pkg;

  // Payload capacity of one frame and the index width into the payload store
  localparam int unsigned MAX_PAYLOAD = 8;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);

  // Header is one length byte and four identifier bytes
  localparam logic [2:0] HEADER_BYTES = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_BAD_ID  = 2'd2;

  // Header byte positions
  localparam logic [2:0] HB_LENGTH = 3'd0;
  localparam logic [2:0] HB_ID_LO  = 3'd1;
  localparam logic [2:0] HB_ID_MID = 3'd2;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SKIP    = 2'd2
  } phase_t;

  // One result item
  typedef struct packed {
    logic [1:0]                        status;
    logic [10:0]                       frame_id;
    logic [3:0]                        frame_len;
    logic [MAX_PAYLOAD-1:0][7:0]       data;
  } result_t;

endpackage

// ----- design/crd_core.sv -----
// ----------------------------------------------------------------------------
// crd_core
// Record parser. Consumes one byte per step, tracks header, payload and skip
// phases and forms the result of a record on the byte that completes it.
// ----------------------------------------------------------------------------
module crd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  output logic              res_valid,
  output crd_pkg::result_t  res
);

  crd_pkg::phase_t phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  record_length, record_length_next;
  logic [10:0] id_value, id_value_next;
  logic        id_overflow, id_overflow_next;
  logic [3:0]  payload_count, payload_count_next;
  logic [7:0]  skip_left, skip_left_next;
  logic [crd_pkg::MAX_PAYLOAD-1:0][7:0] payload_store;

  logic                      store_we;
  logic [crd_pkg::IDX_W-1:0] store_idx;

  // Next state and result for the byte in hand
  always_comb begin
    logic [7:0] skip_dec;
    logic [3:0] count_inc;
    logic [2:0] hc_inc;
    logic       finish;
    logic       bad_len;
    logic [crd_pkg::MAX_PAYLOAD-1:0][7:0] store_view;

    phase_next         = phase;
    header_count_next  = header_count;
    record_length_next = record_length;
    id_value_next      = id_value;
    id_overflow_next   = id_overflow;
    payload_count_next = payload_count;
    skip_left_next     = skip_left;
    store_we           = 1'b0;
    store_idx          = payload_count[crd_pkg::IDX_W-1:0];
    finish             = 1'b0;
    bad_len            = 1'b0;
    skip_dec           = skip_left - {7'd0, (skip_left != 8'd0)};
    count_inc          = payload_count + 4'd1;
    hc_inc             = header_count + 3'd1;

    unique case (phase)
      crd_pkg::PH_SKIP: begin
        // Count down the oversized record, flag it on its last byte
        skip_left_next = skip_dec;
        if (skip_dec == 8'd0) begin
          bad_len = 1'b1;
        end
      end
      crd_pkg::PH_PAYLOAD: begin
        // Store the payload byte and close the record on its last byte
        store_we           = (payload_count < 4'(crd_pkg::MAX_PAYLOAD));
        payload_count_next = count_inc;
        if ({4'd0, count_inc} >= record_length) begin
          finish = 1'b1;
        end
      end
      default: begin
        // Header bytes: length, then the identifier least significant first
        phase_next = crd_pkg::PH_HEADER;
        case (header_count)
          crd_pkg::HB_LENGTH: begin
            record_length_next = byte_in;
            id_value_next      = 11'd0;
            id_overflow_next   = 1'b0;
          end
          crd_pkg::HB_ID_LO: begin
            id_value_next = {id_value[10:8], byte_in};
          end
          crd_pkg::HB_ID_MID: begin
            id_value_next = {byte_in[2:0], id_value[7:0]};
            if (byte_in[7:3] != 5'd0) begin
              id_overflow_next = 1'b1;
            end
          end
          default: begin
            if (byte_in != 8'd0) begin
              id_overflow_next = 1'b1;
            end
          end
        endcase
        header_count_next = hc_inc;
        if (hc_inc >= crd_pkg::HEADER_BYTES) begin
          header_count_next  = 3'd0;
          payload_count_next = 4'd0;
          if (record_length_next > 8'(crd_pkg::MAX_PAYLOAD)) begin
            phase_next     = crd_pkg::PH_SKIP;
            skip_left_next = record_length_next;
          end else if (record_length_next == 8'd0) begin
            finish = 1'b1;
          end else begin
            phase_next = crd_pkg::PH_PAYLOAD;
          end
        end
      end
    endcase

    // Payload as seen after this byte is written
    store_view = payload_store;
    if (store_we) begin
      store_view[store_idx] = byte_in;
    end

    // Form the result
    res       = '0;
    res_valid = finish || bad_len;
    if (bad_len) begin
      res.status = crd_pkg::ST_BAD_LEN;
    end else if (finish && id_overflow_next) begin
      res.status = crd_pkg::ST_BAD_ID;
    end else if (finish) begin
      res.status    = crd_pkg::ST_GOOD;
      res.frame_id  = id_value_next;
      res.frame_len = record_length_next[3:0];
      for (int k = 0; k < crd_pkg::MAX_PAYLOAD; k++) begin
        if (8'(k) < record_length_next) begin
          res.data[k] = store_view[k];
        end
      end
    end

    // Restart the parser after any result
    if (res_valid) begin
      phase_next         = crd_pkg::PH_HEADER;
      header_count_next  = 3'd0;
      payload_count_next = 4'd0;
      skip_left_next     = 8'd0;
    end
  end

  // Advance control state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= crd_pkg::PH_HEADER;
      header_count  <= 3'd0;
      record_length <= 8'd0;
      id_value      <= 11'd0;
      id_overflow   <= 1'b0;
      payload_count <= 4'd0;
      skip_left     <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      record_length <= record_length_next;
      id_value      <= id_value_next;
      id_overflow   <= id_overflow_next;
      payload_count <= payload_count_next;
      skip_left     <= skip_left_next;
    end
  end

  // Payload store, written one byte at a time
  always_ff @(posedge clk) begin
    if (step && store_we) begin
      payload_store[store_idx] <= byte_in;
    end
  end

endmodule

// ----- design/crd_result_reg.sv -----
// ----------------------------------------------------------------------------
// crd_result_reg
// Output register of the deframer. Holds a result until the downstream side
// takes the transfer and loads the next one in the same cycle.
// ----------------------------------------------------------------------------
module crd_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              load,
  input  crd_pkg::result_t  res,
  output logic              valid,
  output crd_pkg::result_t  held
);

  // Take a new result, or go empty, whenever the register is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      held <= res;
    end
  end

endmodule

// ----- design/can_record_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// can_record_deframer_unit
// Length-prefixed record deframer: turns a byte stream of records into
// standard data frames or error reports.
// ----------------------------------------------------------------------------
// Path: the byte that completes a result is held in the input register, and
// the result in the output register. Throughput: one byte per cycle unless
// the output stalls, set by the single parser stage between the registers.
// Reset: synchronous; clears the parser to the header phase and empties both
// registers. Payload bytes are not cleared.
// ----------------------------------------------------------------------------
module can_record_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  stream_byte,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [1:0]  status,
  output logic [10:0] frame_id,
  output logic [3:0]  frame_len,
  output logic [7:0]  data_0,
  output logic [7:0]  data_1,
  output logic [7:0]  data_2,
  output logic [7:0]  data_3,
  output logic [7:0]  data_4,
  output logic [7:0]  data_5,
  output logic [7:0]  data_6,
  output logic [7:0]  data_7
);

  logic             in_full;
  logic [7:0]       in_byte;
  logic             advance;
  logic             step;
  logic             core_valid;
  crd_pkg::result_t core_res;
  crd_pkg::result_t held;

  // Move when the output register is free or its transfer completes
  assign advance    = !frame_valid || !frame_stall;
  assign step       = in_full && advance;
  assign byte_stall = in_full && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!byte_stall) begin
      in_full <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      in_byte <= stream_byte;
    end
  end

  crd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (in_byte),
    .res_valid (core_valid),
    .res       (core_res)
  );

  crd_result_reg u_result (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .load    (step && core_valid),
    .res     (core_res),
    .valid   (frame_valid),
    .held    (held)
  );

  // Unpack the result onto the ports
  assign status    = held.status;
  assign frame_id  = held.frame_id;
  assign frame_len = held.frame_len;
  assign data_0    = held.data[0];
  assign data_1    = held.data[1];
  assign data_2    = held.data[2];
  assign data_3    = held.data[3];
  assign data_4    = held.data[4];
  assign data_5    = held.data[5];
  assign data_6    = held.data[6];
  assign data_7    = held.data[7];

  // Input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (frame_valid && frame_stall))
    else $error("input stalled without a stalled result");

  // Status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (status == crd_pkg::ST_GOOD || status == crd_pkg::ST_BAD_LEN ||
                     status == crd_pkg::ST_BAD_ID))
    else $error("undefined status code");

  // Error reports carry no frame contents
  a_error_clear: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && status != crd_pkg::ST_GOOD) |->
      (frame_id == 11'd0 && frame_len == 4'd0 && data_0 == 8'd0 && data_7 == 8'd0))
    else $error("error report with frame contents");

  // Good frames never exceed the payload capacity
  a_good_len: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && status == crd_pkg::ST_GOOD) |->
      (frame_len <= 4'(crd_pkg::MAX_PAYLOAD)))
    else $error("good frame longer than payload capacity");

endmodule
